@@ src/kvt_pkg.sv @@
// Shared types and constants for the key/value table block.
// Used by kvt_mem, kvt_match and key_value_table_unit; depends on nothing.
package kvt_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int OP_W          = 2;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } kvt_state_t;

  // Write enables of the two table memories
  typedef struct packed {
    logic tag;
    logic value;
  } kvt_wr_en_t;

  // Search outcome of one scan
  typedef struct packed {
    logic hit;
    logic free;
  } kvt_hit_t;

endpackage

@@ src/kvt_mem.sv @@
// Table storage: a tag memory ({valid, key}) and a value memory.
// One write port and one registered read port each; depends on kvt_pkg.
module kvt_mem
  import kvt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk,
  input  kvt_wr_en_t         wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic               wr_tag_valid,
  input  logic [KEY_W-1:0]   wr_key,
  input  logic [VALUE_W-1:0] wr_value,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic               rd_tag_valid,
  output logic [KEY_W-1:0]   rd_key,
  output logic [VALUE_W-1:0] rd_value
);

  logic [KEY_W:0]     tag_mem [CAPACITY];
  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic [KEY_W:0]     tag_rd_r;
  logic [VALUE_W-1:0] value_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en.tag) begin
      tag_mem[wr_addr] <= {wr_tag_valid, wr_key};
    end
    if (rd_en) begin
      tag_rd_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en.value) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      value_rd_r <= value_mem[rd_addr];
    end
  end

  assign rd_tag_valid = tag_rd_r[KEY_W];
  assign rd_key       = tag_rd_r[KEY_W-1:0];
  assign rd_value     = value_rd_r;

endmodule

@@ src/kvt_match.sv @@
// Shared key comparator for the linear search: checks one entry a cycle and
// keeps the first matching slot and the lowest free slot. Depends on kvt_pkg.
module kvt_match
  import kvt_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               rd_issue,
  input  logic [AW-1:0]      rd_idx,
  input  logic               rd_tag_valid,
  input  logic [KEY_W-1:0]   rd_key,
  input  logic [VALUE_W-1:0] rd_value,
  input  logic [KEY_W-1:0]   key,
  output kvt_hit_t           result,
  output logic [AW-1:0]      hit_idx,
  output logic [AW-1:0]      free_idx,
  output logic [VALUE_W-1:0] hit_value
);

  logic               cmp_vld_r;
  logic [AW-1:0]      cmp_idx_r;
  logic               hit_r, hit_nxt;
  logic               free_r, free_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [VALUE_W-1:0] hit_value_r, hit_value_nxt;
  logic               key_eq;

  assign key_eq = (rd_key == key);

  always_comb begin
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    hit_value_nxt = hit_value_r;
    if (start) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (cmp_vld_r) begin
      // keep only the first hit and the lowest free slot
      if (rd_tag_valid && key_eq && !hit_r) begin
        hit_nxt       = 1'b1;
        hit_idx_nxt   = cmp_idx_r;
        hit_value_nxt = rd_value;
      end
      if (!rd_tag_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      cmp_vld_r <= rd_issue;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= rd_idx;
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_value_r <= hit_value_nxt;
  end

  assign result.hit  = hit_r;
  assign result.free = free_r;
  assign hit_idx     = hit_idx_r;
  assign free_idx    = free_idx_r;
  assign hit_value   = hit_value_r;

endmodule

@@ src/key_value_table_unit.sv @@
// Top level of the key/value table: sequencer, entry count and result register.
// Instantiates kvt_mem and kvt_match; depends on kvt_pkg.
//
// Fixed-capacity key/value table searched linearly. Each operation (insert or
// update, lookup, remove) is accepted only while in_stall is low and gives one
// result word. The block takes no new operation until the last one is done:
// one comparator walks the table one entry per cycle through the single read
// port of the table memory, then a drain state empties the read pipe and a
// finish state writes back and loads the result, waiting while the result
// register is full and stalled. A finished result waits in its own register,
// so the next operation may be accepted while out_stall holds it. After reset
// the block runs a clearing pass that marks every entry free; in_stall is high then.
module key_value_table_unit
  import kvt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic [VALUE_W-1:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_was_present,
  output logic [VALUE_W-1:0]       out_value_out,
  output logic [ENTRY_COUNT_W-1:0] out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  kvt_state_t state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;

  logic               accept;
  logic               load;
  logic               rd_issue;
  kvt_wr_en_t         wr_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_tag_valid;
  logic [KEY_W-1:0]   wr_key;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0] res_value;

  logic               rd_tag_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_value;
  kvt_hit_t           srch;
  logic [AW-1:0]      hit_idx;
  logic [AW-1:0]      free_idx;
  logic [VALUE_W-1:0] hit_value;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_was_present_r;
  logic [VALUE_W-1:0]       out_value_out_r;
  logic [ENTRY_COUNT_W-1:0] out_entry_count_r;

  kvt_mem #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_mem (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_tag_valid (wr_tag_valid),
    .wr_key       (wr_key),
    .wr_value     (value_r),
    .rd_en        (rd_issue),
    .rd_addr      (scan_r),
    .rd_tag_valid (rd_tag_valid),
    .rd_key       (rd_key),
    .rd_value     (rd_value)
  );

  kvt_match #(
    .AW (AW)
  ) u_match (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept),
    .rd_issue     (rd_issue),
    .rd_idx       (scan_r),
    .rd_tag_valid (rd_tag_valid),
    .rd_key       (rd_key),
    .rd_value     (rd_value),
    .key          (key_r),
    .result       (srch),
    .hit_idx      (hit_idx),
    .free_idx     (free_idx),
    .hit_value    (hit_value)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    scan_nxt     = scan_r;
    count_nxt    = count_r;
    rd_issue     = 1'b0;
    load         = 1'b0;
    wr_en        = '0;
    wr_addr      = hit_idx;
    wr_tag_valid = 1'b0;
    wr_key       = key_r;
    res_status   = ST_OK;
    res_value    = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en.tag = 1'b1;
        wr_addr   = clr_r;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_issue = 1'b1;
        if (scan_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_INSERT: begin
              if (srch.hit) begin
                wr_en.value = 1'b1;
              end else if (srch.free) begin
                wr_en.tag    = 1'b1;
                wr_en.value  = 1'b1;
                wr_addr      = free_idx;
                wr_tag_valid = 1'b1;
                count_nxt    = count_r + CW'(1);
              end else begin
                res_status = ST_FULL;
              end
            end
            OP_LOOKUP: begin
              if (srch.hit) begin
                res_value = hit_value;
              end else begin
                res_status = ST_ABSENT;
              end
            end
            OP_REMOVE: begin
              if (srch.hit) begin
                wr_en.tag = 1'b1;
                if (count_r != '0) begin
                  count_nxt = count_r - CW'(1);
                end
              end else begin
                res_status = ST_ABSENT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      scan_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (load) begin
      out_status_r      <= res_status;
      out_was_present_r <= srch.hit;
      out_value_out_r   <= res_value;
      out_entry_count_r <= ENTRY_COUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_was_present = out_was_present_r;
  assign out_value_out   = out_value_out_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_status == ST_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("table full reported with free entries");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en.tag || wr_en.value) |-> (state_r == S_CLEAR || load))
    else $error("table write outside clearing pass or write-back");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN && scan_r == '0))
    else $error("accepted word did not start a scan");

  a_hit_not_free_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (load && op_r == OP_INSERT && !srch.hit && srch.free) |=>
      (count_r == $past(count_r) + CW'(1)))
    else $error("new entry did not raise the count");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for key_value_table_unit: directed script, then random traffic.
// Depends on kvt_pkg and the key_value_table_unit RTL.
module tb
  import kvt_pkg::*;
();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SCRIPT_ROWS = 21;
  localparam int RANDOM_OPS  = 1400;
  localparam int POOL_KEYS   = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int OP_CYCLES   = CAPACITY_DEF + 3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     was_present;
    logic [VALUE_W-1:0]       value_out;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } table_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [4:0]         reps;
    logic               typed;
    table_reply_t       reply;
  } script_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_opcode;
  logic signed [KEY_W-1:0]  in_key;
  logic [VALUE_W-1:0]       in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_was_present;
  logic [VALUE_W-1:0]       out_value_out;
  logic [ENTRY_COUNT_W-1:0] out_entry_count;

  // Shadow copy of the table
  bit                       slot_used [CAPACITY_DEF];
  logic [KEY_W-1:0]         slot_key  [CAPACITY_DEF];
  logic [VALUE_W-1:0]       slot_val  [CAPACITY_DEF];
  logic [ENTRY_COUNT_W-1:0] used_count;

  table_reply_t pending_replies [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;

  // Rows with reps above one step key and value by one per word.
  script_row_t script [SCRIPT_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, '{ST_ABSENT, 1'b0, 32'h0, 5'd0}},
    '{OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, '{ST_ABSENT, 1'b0, 32'h0, 5'd0}},
    '{OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd0}},
    '{OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd1}},
    '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd2}},
    '{OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'hFFFF_FFFF, 5'd2}},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd2}},
    '{OP_INSERT, 32'h8000_0000, 32'h1234_5678, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd2}},
    '{OP_UNUSED, 32'h8000_0000, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd2}},
    '{OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd1}},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, '{ST_ABSENT, 1'b0, 32'h0, 5'd1}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0001, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd2}},
    '{OP_INSERT, 32'h0000_0001, 32'hA5A5_0000, 14, 0, '0},
    '{OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1, 1, '{ST_FULL, 1'b0, 32'h0, 5'd16}},
    '{OP_INSERT, 32'h0000_0005, 32'hDEAD_BEEF, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd16}},
    '{OP_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'hDEAD_BEEF, 5'd16}},
    '{OP_UNUSED, 32'h0000_0000, 32'h0000_0000, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd16}},
    '{OP_REMOVE, 32'h0000_0001, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'h0, 5'd15}},
    '{OP_INSERT, 32'h0000_0000, 32'h5555_5555, 1, 1, '{ST_OK, 1'b0, 32'h0, 5'd16}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'h5555_5555, 5'd16}},
    '{OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1, 1, '{ST_OK, 1'b1, 32'h1234_5678, 5'd16}}
  };

  key_value_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_was_present (out_was_present),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow table and return the reply it gives.
  function automatic table_reply_t table_apply(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [VALUE_W-1:0] value);
    table_reply_t r;
    int           hit_slot;
    int           open_slot;
    int           i;
    hit_slot  = -1;
    open_slot = -1;
    for (i = 0; i < CAPACITY_DEF; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit_slot < 0) hit_slot = i;
      if (!slot_used[i] && open_slot < 0) open_slot = i;
    end
    r             = '0;
    r.status      = ST_OK;
    r.was_present = (hit_slot >= 0);
    case (op)
      OP_INSERT: begin
        if (hit_slot >= 0) begin
          slot_val[hit_slot] = value;
        end else if (open_slot >= 0) begin
          slot_used[open_slot] = 1'b1;
          slot_key[open_slot]  = key;
          slot_val[open_slot]  = value;
          used_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit_slot >= 0) r.value_out = slot_val[hit_slot];
        else r.status = ST_ABSENT;
      end
      OP_REMOVE: begin
        if (hit_slot >= 0) begin
          slot_used[hit_slot] = 1'b0;
          if (used_count != 0) used_count--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    r.entry_count = used_count;
    return r;
  endfunction

  // Offer one word, hold it until taken, then record the reply it owes.
  task automatic offer_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [VALUE_W-1:0] value, input bit typed,
                          input table_reply_t typed_reply);
    table_reply_t r;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    in_value  <= value;
    do @(posedge clk); while (in_stall);
    r = table_apply(op, key, value);
    if (typed) r = typed_reply;
    pending_replies.push_back(r);
  endtask

  task automatic hold_until_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [KEY_W-1:0]   key_pool [POOL_KEYS];
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    int                 row;
    int                 rep;
    int                 n;
    int                 pick;
    int                 insert_pct;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_opcode  = OP_INSERT;
    in_key     = '0;
    in_value   = '0;
    used_count = '0;
    for (row = 0; row < CAPACITY_DEF; row++) begin
      slot_used[row] = 1'b0;
      slot_key[row]  = '0;
      slot_val[row]  = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < SCRIPT_ROWS; row++)
      for (rep = 0; rep < script[row].reps; rep++)
        offer_op(script[row].op, script[row].key + rep, script[row].value + rep,
                 script[row].typed, script[row].reply);

    // Small key pool so hits, updates and a full table are common.
    for (n = 0; n < POOL_KEYS; n++) key_pool[n] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    insert_pct = 50;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        insert_pct = $urandom_range(75, 25);
        repeat (3) key_pool[$urandom_range(POOL_KEYS - 1)] = $urandom;
      end
      if (n == 200) hold_req = 1'b1;
      if (n == 700) hold_until_drained();
      quiet = (n >= 900 && n < 1100);
      pick = $urandom_range(99);
      if (pick < 5) op = OP_UNUSED;
      else if (pick < 5 + insert_pct * 95 / 100) op = OP_INSERT;
      else if ($urandom_range(1)) op = OP_LOOKUP;
      else op = OP_REMOVE;
      if ($urandom_range(9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(POOL_KEYS - 1)];
      offer_op(op, key, $urandom, 1'b0, '0);
    end

    hold_until_drained();
    repeat (2 * OP_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= (!quiet && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("reply word with no operation outstanding");
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_was_present !== want.was_present) begin
          $error("was_present: expected %0d, got %0d", want.was_present, out_was_present);
          mismatches++;
        end
        if (out_value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_value_out);
          mismatches++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
src/kvt_pkg.sv
src/kvt_mem.sv
src/kvt_match.sv
src/key_value_table_unit.sv
verif/tb.sv
